### hw/rtl/thq_pkg.sv
// Shared constants and types for the terrain height query block.
`timescale 1ns / 1ps
package thq_pkg;

	// Height grid geometry.
	localparam int GRID_DIM   = 256;
	localparam int IDX_W      = $clog2(GRID_DIM);
	localparam int HALF_W     = IDX_W - 1;
	localparam int BANK_AW    = 2 * HALF_W;
	localparam int BANK_DEPTH = GRID_DIM * GRID_DIM / 4;
	localparam int NUM_BANKS  = 4;

	// Fixed-point formats.
	localparam int COORD_W  = 24;
	localparam int INV_W    = 24;
	localparam int CELLS_W  = 8;
	localparam int HEIGHT_W = 16;
	localparam int FRAC_W   = 24;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * (COORD_W + 1);
	localparam int CELL_W   = PROD_W - 1 - FRAC_W;
	localparam int WGT_W    = FRAC_W + 1;
	localparam int DH_W     = HEIGHT_W + 1;
	localparam int MUL_W    = WGT_W + 1 + DH_W;
	localparam int ACC_W    = MUL_W + 2;
	localparam int HQ_W     = ACC_W - FRAC_W;

	// Configuration port.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 24;

	typedef enum logic [CFG_AW-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Z   = 3'd1,
		REG_INV_CELL_W = 3'd2,
		REG_INV_CELL_H = 3'd3,
		REG_CELLS_W    = 3'd4,
		REG_CELLS_H    = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// Input word layout.
	localparam int IN_DATA_W = 80;

	// Write fields carried through the front of the pipeline.
	typedef struct packed {
		logic [IDX_W-1:0]    col;
		logic [IDX_W-1:0]    row;
		logic [HEIGHT_W-1:0] value;
	} wr_fields_t;

endpackage

### hw/rtl/terrain_height_query.sv
// Terrain height query: banked height grid with barycentric interpolation pipeline.
// One word is accepted every cycle; a held result stalls all stages together.
// Height writes are committed in stage 4, in order with queries, and give no result.
// arst_n clears the stage valid bits and loads the configuration reset values.
// The height store is not cleared; an entry reads as undefined until written.
`timescale 1ns / 1ps
module terrain_height_query (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x[23:0], pos_z[47:24], grid_col[55:48], grid_row[63:56], height_value[79:64]
	input  logic [thq_pkg::IN_DATA_W-1:0]    s_tdata,
	// func[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// height[15:0]
	output logic [thq_pkg::HEIGHT_W-1:0]     m_tdata,
	// in_range[0]
	output logic                             m_tuser,
	input  logic                             cfg_we,
	input  logic [thq_pkg::CFG_AW-1:0]       cfg_addr,
	input  logic [thq_pkg::CFG_DW-1:0]       cfg_wdata
);

	localparam int CW  = thq_pkg::COORD_W;
	localparam int FW  = thq_pkg::FRAC_W;
	localparam int HW  = thq_pkg::HEIGHT_W;
	localparam int IW  = thq_pkg::IDX_W;
	localparam int AW  = thq_pkg::BANK_AW;
	localparam int HFW = thq_pkg::HALF_W;

	// Configuration registers.
	logic signed [CW-1:0]              origin_x_q, origin_z_q;
	logic [thq_pkg::INV_W-1:0]         inv_cell_w_q, inv_cell_h_q;
	logic [thq_pkg::CELLS_W-1:0]       cells_w_q, cells_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_z_q   <= '0;
			inv_cell_w_q <= thq_pkg::INV_W'(65536);
			inv_cell_h_q <= thq_pkg::INV_W'(65536);
			cells_w_q    <= thq_pkg::CELLS_W'(255);
			cells_h_q    <= thq_pkg::CELLS_W'(255);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				thq_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_wdata[CW-1:0];
				thq_pkg::REG_ORIGIN_Z:   origin_z_q   <= cfg_wdata[CW-1:0];
				thq_pkg::REG_INV_CELL_W: inv_cell_w_q <= cfg_wdata[thq_pkg::INV_W-1:0];
				thq_pkg::REG_INV_CELL_H: inv_cell_h_q <= cfg_wdata[thq_pkg::INV_W-1:0];
				thq_pkg::REG_CELLS_W:    cells_w_q    <= cfg_wdata[thq_pkg::CELLS_W-1:0];
				thq_pkg::REG_CELLS_H:    cells_h_q    <= cfg_wdata[thq_pkg::CELLS_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: every stage moves when the output slot is free or drains.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input field unpacking.
	logic signed [CW-1:0]  in_pos_x, in_pos_z;
	thq_pkg::wr_fields_t   in_wr;
	assign in_pos_x    = s_tdata[CW-1:0];
	assign in_pos_z    = s_tdata[2*CW-1:CW];
	assign in_wr.col   = s_tdata[2*CW+IW-1:2*CW];
	assign in_wr.row   = s_tdata[2*CW+2*IW-1:2*CW+IW];
	assign in_wr.value = s_tdata[2*CW+2*IW+HW-1:2*CW+2*IW];

	// Stage valid bits and item kind.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic q_s1, q_s2, q_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			// Write items retire at the store and leave no result behind.
			v_s4 <= v_s3 && q_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: offset from the terrain origin.
	logic signed [thq_pkg::DIFF_W-1:0] tx_s1, tz_s1;
	thq_pkg::wr_fields_t               wr_s1, wr_s2, wr_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1  <= (s_tuser == thq_pkg::FUNC_QUERY);
			tx_s1 <= {in_pos_x[CW-1], in_pos_x} - {origin_x_q[CW-1], origin_x_q};
			tz_s1 <= {in_pos_z[CW-1], in_pos_z} - {origin_z_q[CW-1], origin_z_q};
			wr_s1 <= in_wr;
		end
	end

	// Stage 2: scale by the reciprocal cell size into Q.24 grid units.
	logic signed [thq_pkg::PROD_W-1:0] px_s2, pz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2  <= q_s1;
			px_s2 <= tx_s1 * $signed({1'b0, inv_cell_w_q});
			pz_s2 <= tz_s1 * $signed({1'b0, inv_cell_h_q});
			wr_s2 <= wr_s1;
		end
	end

	// Stage 3: cell index, fraction, range check and triangle choice.
	logic [thq_pkg::CELL_W-1:0] cell_x, cell_z;
	logic                       ok_x, ok_z;
	logic [FW:0]                frac_sum;
	logic [IW-1:0]              gx_s3, gz_s3;
	logic [FW-1:0]              fx_s3, fz_s3;
	logic                       inr_s3, lower_s3;

	assign cell_x   = px_s2[thq_pkg::PROD_W-2:FW];
	assign cell_z   = pz_s2[thq_pkg::PROD_W-2:FW];
	assign ok_x     = !px_s2[thq_pkg::PROD_W-1]
	               && (cell_x < thq_pkg::CELL_W'(cells_w_q))
	               && (cell_x < thq_pkg::CELL_W'(thq_pkg::GRID_DIM - 1));
	assign ok_z     = !pz_s2[thq_pkg::PROD_W-1]
	               && (cell_z < thq_pkg::CELL_W'(cells_h_q))
	               && (cell_z < thq_pkg::CELL_W'(thq_pkg::GRID_DIM - 1));
	assign frac_sum = {1'b0, px_s2[FW-1:0]} + {1'b0, pz_s2[FW-1:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3     <= q_s2;
			gx_s3    <= cell_x[IW-1:0];
			gz_s3    <= cell_z[IW-1:0];
			fx_s3    <= px_s2[FW-1:0];
			fz_s3    <= pz_s2[FW-1:0];
			inr_s3   <= ok_x && ok_z;
			lower_s3 <= (frac_sum <= (FW+1)'(1 << FW));
			wr_s3    <= wr_s2;
		end
	end

	// Stage 4: four banks split by column and row parity, so the corners of
	// any cell sit in different banks and are read together.
	logic [HW-1:0] mem_q [thq_pkg::NUM_BANKS][thq_pkg::BANK_DEPTH];
	logic [AW-1:0] raddr [thq_pkg::NUM_BANKS];
	logic [1:0]    wbank;
	logic [AW-1:0] waddr;
	logic          mem_we, mem_re;

	assign mem_we = en && v_s3 && !q_s3;
	assign mem_re = en && v_s3 && q_s3;
	assign wbank  = {wr_s3.row[0], wr_s3.col[0]};
	assign waddr  = {wr_s3.row[IW-1:1], wr_s3.col[IW-1:1]};

	always_comb begin
		for (int b = 0; b < thq_pkg::NUM_BANKS; b++) begin
			// An odd base index takes the neighbor row or column from the
			// even bank one address further on.
			raddr[b] = {gz_s3[IW-1:1] + HFW'(gz_s3[0] & ~b[1]),
			            gx_s3[IW-1:1] + HFW'(gx_s3[0] & ~b[0])};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wbank][waddr] <= wr_s3.value;
		end
	end

	logic [HW-1:0] rd_s4 [thq_pkg::NUM_BANKS];
	logic [FW-1:0] fx_s4, fz_s4;
	logic          inr_s4, lower_s4, px_s4, pz_s4;

	always_ff @(posedge clk) begin
		if (mem_re) begin
			for (int b = 0; b < thq_pkg::NUM_BANKS; b++) begin
				rd_s4[b] <= mem_q[b][raddr[b]];
			end
		end
		if (en) begin
			fx_s4    <= fx_s3;
			fz_s4    <= fz_s3;
			inr_s4   <= inr_s3;
			lower_s4 <= lower_s3;
			px_s4    <= gx_s3[0];
			pz_s4    <= gz_s3[0];
		end
	end

	// Stage 5: pick the triangle's corners, edge deltas and weights.
	logic signed [HW-1:0]         h00, h10, h01, h11;
	logic signed [HW-1:0]         base_s5;
	logic signed [thq_pkg::DH_W-1:0] da_s5, db_s5;
	logic [thq_pkg::WGT_W-1:0]    wa_s5, wb_s5;
	logic                         inr_s5;

	assign h00 = rd_s4[{pz_s4, px_s4}];
	assign h10 = rd_s4[{pz_s4, ~px_s4}];
	assign h01 = rd_s4[{~pz_s4, px_s4}];
	assign h11 = rd_s4[{~pz_s4, ~px_s4}];

	always_ff @(posedge clk) begin
		if (en) begin
			inr_s5 <= inr_s4;
			if (lower_s4) begin
				base_s5 <= h00;
				da_s5   <= {h10[HW-1], h10} - {h00[HW-1], h00};
				db_s5   <= {h01[HW-1], h01} - {h00[HW-1], h00};
				wa_s5   <= {1'b0, fx_s4};
				wb_s5   <= {1'b0, fz_s4};
			end else begin
				base_s5 <= h11;
				da_s5   <= {h10[HW-1], h10} - {h11[HW-1], h11};
				db_s5   <= {h01[HW-1], h01} - {h11[HW-1], h11};
				wa_s5   <= thq_pkg::WGT_W'(1 << FW) - {1'b0, fz_s4};
				wb_s5   <= thq_pkg::WGT_W'(1 << FW) - {1'b0, fx_s4};
			end
		end
	end

	// Stage 6: weight both edge deltas.
	logic signed [thq_pkg::MUL_W-1:0] ma_s6, mb_s6;
	logic signed [HW-1:0]             base_s6;
	logic                             inr_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s6   <= $signed({1'b0, wa_s5}) * da_s5;
			mb_s6   <= $signed({1'b0, wb_s5}) * db_s5;
			base_s6 <= base_s5;
			inr_s6  <= inr_s5;
		end
	end

	// Stage 7: sum in Q.24 with the half-LSB rounding bias folded in.
	logic signed [thq_pkg::ACC_W-1:0] acc_s7;
	logic                             inr_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s7 <= ($signed(thq_pkg::ACC_W'(base_s6)) <<< FW)
			        + thq_pkg::ACC_W'(ma_s6) + thq_pkg::ACC_W'(mb_s6)
			        + $signed(thq_pkg::ACC_W'(1 << (FW - 1)));
			inr_s7 <= inr_s6;
		end
	end

	// Stage 8: drop the fraction (floor), saturate, zero when out of range.
	logic signed [thq_pkg::HQ_W-1:0] hq;
	logic signed [HW-1:0]            hsat;

	assign hq = acc_s7[thq_pkg::ACC_W-1:FW];

	always_comb begin
		priority if (hq > $signed(thq_pkg::HQ_W'(32767))) begin
			hsat = 16'sh7FFF;
		end else if (hq < -$signed(thq_pkg::HQ_W'(32768))) begin
			hsat = 16'sh8000;
		end else begin
			hsat = hq[HW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= inr_s7 ? hsat : '0;
			m_tuser <= inr_s7;
		end
	end

	assign m_tvalid = v_s8;

	// A result outside the grid always reads as zero height.
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("out-of-range result carries a nonzero height");

	// A query in stage 7 reaches the output on the next advance.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s7 |=> m_tvalid)
		else $error("query dropped between last stages");

	// A stalled pipeline keeps its items in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s4 |=> v_s4 && $stable(inr_s4))
		else $error("stage 4 changed during a stall");

	// An in-range cell always has a neighbor vertex inside the store.
	a_cell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && q_s3 && inr_s3 |-> gx_s3 != '1 && gz_s3 != '1)
		else $error("in-range cell on the last grid line");

	// The store is never read and written by the same advance.
	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in one cycle");

endmodule
